// ===== rtl/lssc_pkg.sv =====
// Package with shared types and constants for the spline coefficient core.
package lssc_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned WordW = 32;
  // Width of the signed guard range used for S and T (+-(2^37 - 1)).
  localparam int unsigned GuardW = 38;
  // Width of the working dividend and quotient registers.
  localparam int unsigned WideW = 64;

  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegSlope = 2'd1;
  localparam logic [1:0] RegCurv = 2'd2;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusSat = 2'd1;
  localparam logic [1:0] StatusZeroDx = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StDivS,
    StDivT,
    StDivA,
    StMulW,
    StFinish,
    StOut
  } lssc_state_e;

  // Request to the serial divider.
  typedef struct packed {
    logic             start;
    logic [WideW-1:0] dividend;
    logic [WordW:0]   divisor;
  } lssc_div_req_t;

  // Result of the serial divider.
  typedef struct packed {
    logic             done;
    logic [WideW-1:0] quotient;
  } lssc_div_rsp_t;

endpackage

// ===== rtl/local_spline_segment_coefficients_core.sv =====
// Top level of the local quadratic / cubic spline segment coefficient core.
// Each knot point after the first of a set gives one result transaction. The time a
// point takes is set by the bit-serial divider, which runs 64 steps after a load for
// each of the two (quadratic mode) or three (cubic mode) divisions by the interval
// width. In cubic mode the shift-add product w*dx, one bit a cycle, runs beside the
// third division and adds no time. A zero-width interval gives its result in the next
// cycle. Only one point is in work at a time; a finished result sits in the output
// register until taken, and no new point is accepted while it waits.
module local_spline_segment_coefficients_core #(
  parameter int unsigned FRAC_BITS = lssc_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: x_value[31:0], y_value[63:32]
  input  logic [63:0] s_axis_tdata,
  // tuser: first_point
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: coef_a[31:0], coef_b[63:32], coef_c[95:64], coef_d[127:96], status[129:128]
  output logic [135:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import lssc_pkg::*;

  localparam logic signed [WideW-1:0] GuardMax = WideW'((64'sd1 <<< (GuardW - 1)) - 1);
  localparam logic signed [WideW-1:0] S32Max = 64'sd2147483647;
  localparam logic signed [WideW-1:0] S32Min = -64'sd2147483648;
  localparam int unsigned MulCntW = $clog2(WordW + 2);

  lssc_state_e state_q, state_d;

  logic               mode_q;
  logic signed [31:0] start_slope_q, start_curv_q;
  logic signed [31:0] prev_x_q, prev_y_q, z_q, w_q;
  logic               have_prev_q;
  logic signed [31:0] x_q, y_q;
  logic signed [WordW:0] dx_q;
  logic signed [WideW-1:0] s_q, t_q, a_q;
  logic signed [WideW-1:0] prod_q;
  logic signed [WideW-1:0] mcand_q;
  logic [WordW:0]     mplier_q;
  logic [MulCntW-1:0] mcnt_q;
  logic               sat_q;
  logic [135:0]       out_q;
  logic               out_v_q;

  lssc_div_req_t div_req;
  lssc_div_rsp_t div_rsp;

  lssc_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Saturation helpers on 64-bit values.
  function automatic logic signed [WideW-1:0] clampv(logic signed [WideW-1:0] v,
                                                     logic signed [WideW-1:0] hi,
                                                     logic signed [WideW-1:0] lo);
    clampv = (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  logic signed [WideW-1:0] s_c, t_c, qa, qb, qc, cw, nw;
  logic signed [WideW-1:0] ta, tb, tc;
  logic sat_s;

  always_comb begin
    s_c = clampv($signed(div_rsp.quotient), GuardMax, -GuardMax);
    sat_s = s_c != $signed(div_rsp.quotient);
    t_c = clampv($signed(div_rsp.quotient), GuardMax, -GuardMax);
    // Final coefficients from registered terms.
    tb = 3 * t_q - WideW'(w_q);
    tc = 3 * s_q - 2 * WideW'(z_q) - (prod_q >>> (FRAC_BITS + 1));
    qb = 2 * s_q - WideW'(z_q);
    if (mode_q) begin
      ta = clampv(a_q, S32Max, S32Min);
      tb = clampv(tb, S32Max, S32Min);
      tc = clampv(tc, S32Max, S32Min);
    end else begin
      ta = clampv(t_q, S32Max, S32Min);
      tb = clampv(qb, S32Max, S32Min);
      tc = WideW'(prev_y_q);
    end
    qa = ta;
    qc = tc;
    nw = clampv(2 * tb, S32Max, S32Min);
    cw = 2 * tb;
  end

  // Truncating division of w*dx by 2q: shift toward zero.
  logic signed [WideW-1:0] wdx_div;
  always_comb begin
    wdx_div = prod_q[WideW-1]
      ? -((-prod_q) >>> (FRAC_BITS + 1)) : (prod_q >>> (FRAC_BITS + 1));
  end

  logic signed [WideW-1:0] c_fin, b_fin, a_fin, w_fin;
  logic sat_fin;
  always_comb begin
    c_fin = mode_q ? clampv(3 * s_q - 2 * WideW'(z_q) - wdx_div, S32Max, S32Min) : qc;
    b_fin = tb;
    a_fin = qa;
    w_fin = nw;
    sat_fin = sat_q || (a_fin != (mode_q ? a_q : t_q))
      || (b_fin != (mode_q ? (3 * t_q - WideW'(w_q)) : qb))
      || (mode_q && (c_fin != 3 * s_q - 2 * WideW'(z_q) - wdx_div))
      || (mode_q && (w_fin != cw));
  end

  assign s_axis_tready = (state_q == StIdle) && !out_v_q;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  logic in_go;
  assign in_go = s_axis_tvalid && s_axis_tready;

  // Ordinate step of the interval, formed at full width.
  logic signed [WordW:0] dy_w;
  assign dy_w = {y_q[WordW-1], y_q} - {prev_y_q[WordW-1], prev_y_q};

  // Next state and divider requests.
  always_comb begin
    state_d = state_q;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = dx_q;
    case (state_q)
      StIdle: begin
        if (in_go && !s_axis_tuser && have_prev_q
            && s_axis_tdata[31:0] != prev_x_q) begin
          state_d = StDivS;
        end
      end
      StDivS: begin
        div_req.start = 1'b1;
        div_req.dividend = WideW'(dy_w) <<< FRAC_BITS;
        state_d = StDivT;
      end
      StDivT: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.dividend = (s_c - WideW'(z_q)) <<< FRAC_BITS;
          state_d = StDivA;
        end
      end
      StDivA: begin
        if (div_rsp.done) begin
          if (mode_q) begin
            div_req.start = 1'b1;
            div_req.dividend = (2 * t_c - WideW'(w_q)) <<< (FRAC_BITS - 1);
            state_d = StMulW;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StMulW: begin
        if (div_rsp.done && mcnt_q == '0) state_d = StFinish;
      end
      StFinish: state_d = StOut;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q <= 1'b1;
      start_slope_q <= -32'sd655;
      start_curv_q <= 32'sd1311;
      prev_x_q <= '0;
      prev_y_q <= '0;
      z_q <= '0;
      w_q <= '0;
      have_prev_q <= 1'b0;
      out_v_q <= 1'b0;
      sat_q <= 1'b0;
      mcnt_q <= '0;
      x_q <= '0;
      y_q <= '0;
      dx_q <= '0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegMode: mode_q <= cfg_data_i[0];
          RegSlope: start_slope_q <= cfg_data_i;
          RegCurv: start_curv_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      if (in_go) begin
        x_q <= s_axis_tdata[31:0];
        y_q <= s_axis_tdata[63:32];
        dx_q <= (WordW+1)'($signed(s_axis_tdata[31:0])) - (WordW+1)'(prev_x_q);
        sat_q <= 1'b0;
        if (s_axis_tuser || !have_prev_q) begin
          prev_x_q <= s_axis_tdata[31:0];
          prev_y_q <= s_axis_tdata[63:32];
          z_q <= start_slope_q;
          w_q <= start_curv_q;
          have_prev_q <= 1'b1;
        end else if (s_axis_tdata[31:0] == prev_x_q) begin
          out_q <= {6'd0, StatusZeroDx, 128'd0};
          out_v_q <= 1'b1;
        end
      end
      if (state_q == StDivT && div_rsp.done) sat_q <= sat_q | sat_s;
      if (state_q == StDivA && div_rsp.done) begin
        sat_q <= sat_q | (t_c != $signed(div_rsp.quotient));
        mcnt_q <= MulCntW'(WordW + 1);
      end
      if (state_q == StMulW && mcnt_q != '0) mcnt_q <= mcnt_q - 1'b1;
      if (state_q == StFinish) begin
        out_q <= {6'd0, sat_fin ? StatusSat : StatusOk,
                  mode_q ? prev_y_q : 32'd0, c_fin[31:0], b_fin[31:0], a_fin[31:0]};
        out_v_q <= 1'b1;
        prev_x_q <= x_q;
        prev_y_q <= y_q;
        z_q <= mode_q ? c_fin[31:0] : b_fin[31:0];
        if (mode_q) w_q <= w_fin[31:0];
      end
    end
  end

  // Datapath registers: quotients and the shift-add product w*dx.
  always_ff @(posedge clk_i) begin
    if (state_q == StDivT && div_rsp.done) s_q <= s_c;
    if (state_q == StDivA && div_rsp.done) begin
      t_q <= t_c;
      prod_q <= '0;
      mcand_q <= WideW'(w_q);
      mplier_q <= dx_q;
    end
    if (state_q == StMulW) begin
      if (div_rsp.done) a_q <= $signed(div_rsp.quotient);
      if (mcnt_q != '0) begin
        if (mcnt_q == MulCntW'(1)) begin
          prod_q <= mplier_q[0] ? prod_q - mcand_q : prod_q;
        end else begin
          prod_q <= mplier_q[0] ? prod_q + mcand_q : prod_q;
        end
        mcand_q <= mcand_q <<< 1;
        mplier_q <= mplier_q >> 1;
      end
    end
  end

`ifndef SYNTHESIS
  // Input is refused whenever a point is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready) else $error("input taken while busy");
  // A result appears right after the finish step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) |=> m_axis_tvalid) else $error("result missing");
  // The first point after reset, which starts a set, never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_go && !have_prev_q) |=> !m_axis_tvalid) else $error("result on set start");
`endif

endmodule

// ===== rtl/lssc_divider.sv =====
// Bit-serial signed divider that truncates toward zero, one quotient bit a cycle.
module lssc_divider (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lssc_pkg::lssc_div_req_t req_i,
  output lssc_pkg::lssc_div_rsp_t rsp_o
);
  import lssc_pkg::*;

  localparam int unsigned CntW = $clog2(WideW + 1);

  logic [WideW-1:0] quo_q, quo_d;
  logic [WordW:0]   den_q, den_d;
  logic [WordW+1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;
  logic [WordW+1:0] trial;
  logic [WideW-1:0] num_abs;
  logic [WordW:0]   den_abs;

  // Magnitudes of the operands and one restoring step per cycle.
  always_comb begin
    num_abs = req_i.dividend[WideW-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
    den_abs = req_i.divisor[WordW] ? (~req_i.divisor + 1'b1) : req_i.divisor;
    trial = {rem_q[WordW:0], quo_q[WideW-1]} - {1'b0, den_q};
    quo_d = quo_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    neg_d = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d = num_abs;
      den_d = den_abs;
      rem_d = '0;
      cnt_d = CntW'(WideW);
      busy_d = 1'b1;
      neg_d = req_i.dividend[WideW-1] ^ req_i.divisor[WordW];
    end else if (busy_q) begin
      if (!trial[WordW+1]) begin
        rem_d = trial;
        quo_d = {quo_q[WideW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[WordW:0], quo_q[WideW-1]};
        quo_d = {quo_q[WideW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) begin
          quo_d = ~quo_d + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;

`ifndef SYNTHESIS
  // A finished division always comes from a busy divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("divider done without work");
  // The divider never runs with the count at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != '0)
    else $error("divider busy with empty count");
  // A start always makes the divider busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q)
    else $error("divider failed to start");
`endif

endmodule

// ===== tb/local_spline_segment_coefficients_core_test.sv =====
// Testbench for the spline segment coefficient core: directed and random knot streams.
`timescale 1ns / 100ps

module local_spline_segment_coefficients_core_test;
  import lssc_pkg::*;

  // Expected contents of one result transaction.
  typedef struct {
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] coef_c;
    logic [31:0] coef_d;
    logic [1:0]  status;
  } segment_coef_t;

  localparam longint GuardMax = 64'sd137438953471;
  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;
  localparam int DrainCycles = 300;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  // Predictor copy of the configuration and the running spline state.
  logic   cubic_mode;
  longint set_slope;
  longint set_curv;
  longint knot_x;
  longint knot_y;
  longint run_slope;
  longint run_curv;
  bit     knot_valid;

  segment_coef_t pending_coefs[$];
  int errors = 0;
  int segments_seen = 0;
  int points_sent = 0;
  int saturated_seen = 0;
  int zero_dx_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  local_spline_segment_coefficients_core u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Clamp to a symmetric or word range, noting any change.
  function automatic longint clamp_to(longint v, longint lo, longint hi, inout bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Advance the spline state by one knot; returns 1 when a segment closes.
  function automatic bit predict_segment(logic [31:0] x_raw, logic [31:0] y_raw, logic first,
                                         output segment_coef_t coefs);
    longint x, y, dx, dy, s, t, a, b, c, d, w;
    longint q;
    bit sat;
    x = longint'(signed'(x_raw));
    y = longint'(signed'(y_raw));
    q = 64'sd65536;
    sat = 1'b0;
    coefs = '{default: '0};
    if (first || !knot_valid) begin
      knot_x = x;
      knot_y = y;
      run_slope = set_slope;
      run_curv = set_curv;
      knot_valid = 1'b1;
      return 1'b0;
    end
    dx = x - knot_x;
    dy = y - knot_y;
    if (dx == 0) begin
      coefs.status = StatusZeroDx;
      return 1'b1;
    end
    s = clamp_to(dy * q / dx, -GuardMax, GuardMax, sat);
    t = clamp_to((s - run_slope) * q / dx, -GuardMax, GuardMax, sat);
    if (!cubic_mode) begin
      a = clamp_to(t, WordMin, WordMax, sat);
      b = clamp_to(2 * s - run_slope, WordMin, WordMax, sat);
      c = knot_y;
      d = 0;
      run_slope = b;
    end else begin
      w = run_curv;
      a = clamp_to((2 * t - w) * (q / 2) / dx, WordMin, WordMax, sat);
      b = clamp_to(3 * t - w, WordMin, WordMax, sat);
      c = clamp_to(3 * s - 2 * run_slope - (w * dx) / (2 * q), WordMin, WordMax, sat);
      d = knot_y;
      run_slope = c;
      run_curv = clamp_to(2 * b, WordMin, WordMax, sat);
    end
    knot_x = x;
    knot_y = y;
    coefs.coef_a = a[31:0];
    coefs.coef_b = b[31:0];
    coefs.coef_c = c[31:0];
    coefs.coef_d = d[31:0];
    coefs.status = sat ? StatusSat : StatusOk;
    return 1'b1;
  endfunction

  // Receiver ready: random idling, or a counted hold-off when requested.
  always @(posedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_coefs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        segment_coef_t exp_c;
        exp_c = pending_coefs.pop_front();
        segments_seen++;
        if (m_axis_tdata[31:0] !== exp_c.coef_a)
          $display("%0t: coef_a expected %h actual %h", $time, exp_c.coef_a, m_axis_tdata[31:0]);
        if (m_axis_tdata[63:32] !== exp_c.coef_b)
          $display("%0t: coef_b expected %h actual %h", $time, exp_c.coef_b, m_axis_tdata[63:32]);
        if (m_axis_tdata[95:64] !== exp_c.coef_c)
          $display("%0t: coef_c expected %h actual %h", $time, exp_c.coef_c, m_axis_tdata[95:64]);
        if (m_axis_tdata[127:96] !== exp_c.coef_d)
          $display("%0t: coef_d expected %h actual %h", $time, exp_c.coef_d,
                   m_axis_tdata[127:96]);
        if (m_axis_tdata[129:128] !== exp_c.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_c.status,
                   m_axis_tdata[129:128]);
        if (m_axis_tdata[129:0] !== {exp_c.status, exp_c.coef_d, exp_c.coef_c,
                                     exp_c.coef_b, exp_c.coef_a})
          errors++;
      end
    end
  end

  // Send one knot point and record the segment it closes, if any.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic first);
    segment_coef_t coefs;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    s_axis_tuser <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    points_sent++;
    if (predict_segment(x, y, first, coefs)) begin
      pending_coefs = {pending_coefs, coefs};
      if (coefs.status == StatusSat) saturated_seen++;
      if (coefs.status == StatusZeroDx) zero_dx_seen++;
    end
  endtask

  // Stop sending, wait for all results, then let a set start finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register write transaction; only called while the core is idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegMode:  cubic_mode = data[0];
      RegSlope: set_slope = longint'(signed'(data));
      RegCurv:  set_curv = longint'(signed'(data));
      default: ;
    endcase
  endtask

  // Random word with a random magnitude so small steps dominate.
  function automatic logic [31:0] shaped_word();
    int nbits;
    logic [31:0] v;
    nbits = $urandom_range(32, 1);
    v = $urandom();
    if (nbits < 32) begin
      v = v & ((32'h1 << nbits) - 1);
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  // A well-formed set of knots with mostly positive steps, or plain noise.
  task automatic send_random_set();
    logic [31:0] x, y;
    int len;
    len = $urandom_range(8, 2);
    x = $urandom();
    y = $urandom();
    if ($urandom_range(9) < 7) begin
      send_point(x, y, 1'b1);
      repeat (len) begin
        case ($urandom_range(9))
          0: x = $urandom();
          1: ;
          default: x = x + ($urandom_range(1 << $urandom_range(20, 4)) | 1);
        endcase
        y = ($urandom_range(4) == 0) ? $urandom() : y + shaped_word();
        send_point(x, y, 1'b0);
      end
    end else begin
      repeat (len) send_point($urandom(), shaped_word(), $urandom_range(4) == 0);
    end
  endtask

  task automatic random_config();
    case ($urandom_range(3))
      0: write_reg(RegSlope, 32'h7FFF_FFFF);
      1: write_reg(RegSlope, 32'h8000_0000);
      default: write_reg(RegSlope, shaped_word());
    endcase
    case ($urandom_range(3))
      0: write_reg(RegCurv, 32'h8000_0000);
      1: write_reg(RegCurv, 32'h7FFF_FFFF);
      default: write_reg(RegCurv, shaped_word());
    endcase
    write_reg(RegMode, $urandom_range(1));
  endtask

  // Reset settings: cubic mode with the default start terms.
  task automatic test_reset_defaults();
    send_point(32'h0001_0000, 32'h0002_0000, 1'b0);
    send_point(32'h0002_0000, 32'h0003_0000, 1'b0);
    send_point(32'h0004_0000, 32'hFFFF_0000, 1'b0);
    drain();
  endtask

  // Field extremes, zero interval width, mode change inside a set.
  task automatic test_directed_cases();
    write_reg(RegMode, 32'h0);
    write_reg(RegSlope, 32'h0);
    write_reg(RegCurv, 32'h0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h0, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0001, 32'h8000_0000, 1'b0);
    send_point(32'h0, 32'h0, 1'b1);
    send_point(32'h1, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 1'b0);
    drain();
    write_reg(RegMode, 32'h1);
    send_point(32'h0002_0000, 32'h0004_0000, 1'b0);
    send_point(32'h0002_0000, 32'h0, 1'b0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    drain();
    write_reg(RegSlope, 32'h8000_0000);
    write_reg(RegCurv, 32'h7FFF_FFFF);
    send_point(32'h0, 32'h0, 1'b1);
    send_point(32'h0000_0100, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_0000, 32'h7FFF_FFFF, 1'b0);
    drain();
    write_reg(RegSlope, 32'h7FFF_FFFF);
    write_reg(RegCurv, 32'h8000_0000);
    send_point(32'hFFFF_0000, 32'h0, 1'b1);
    send_point(32'h0, 32'h0001_0000, 1'b0);
    send_point(32'h8000_0000, 32'h0, 1'b0);
    drain();
  endtask

  // Random sets in one idling pattern, with a fresh setting before it and now and then between sets.
  task automatic test_random_phase(int snd_pct, int rcv_pct, int n_points);
    int start_cnt;
    random_config();
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start_cnt = points_sent;
    while (points_sent - start_cnt < n_points) begin
      send_random_set();
      if ($urandom_range(15) == 0) begin
        drain();
        random_config();
      end
    end
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering points.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(RegMode, 32'h0);
    recv_hold = 1500;
    send_point(32'h0, 32'h0, 1'b1);
    repeat (6) send_point($urandom_range(200000, 1) + 32'h0010_0000, shaped_word(), 1'b0);
    drain();
  endtask

  // Sender pauses until all results have arrived, then resumes the same set.
  task automatic test_sender_pause();
    send_point(32'h0001_0000, 32'h0000_8000, 1'b1);
    send_point(32'h0003_0000, 32'h0001_8000, 1'b0);
    drain();
    send_point(32'h0004_0000, 32'h0001_0000, 1'b0);
    drain();
  endtask

  initial begin
    cubic_mode = 1'b1;
    set_slope = -655;
    set_curv = 1311;
    knot_x = 0;
    knot_y = 0;
    run_slope = 0;
    run_curv = 0;
    knot_valid = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_cases();
    test_random_phase(20, 67, 300);
    test_random_phase(67, 20, 300);
    test_random_phase(0, 0, 300);
    test_output_backpressure();
    test_sender_pause();
    $display("Sent %0d knot points; checked %0d segments (%0d saturated, %0d zero width).",
             points_sent, segments_seen, saturated_seen, zero_dx_seen);
    $display("Covered both modes, start-term extremes, set restarts and output stalls.");
    if (errors == 0) begin
      $display("local_spline_segment_coefficients_core_test: PASS");
    end else begin
      $display("local_spline_segment_coefficients_core_test: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_coefs.size());
    $display("local_spline_segment_coefficients_core_test: FAIL");
    $finish;
  end

endmodule

// ===== local_spline_segment_coefficients_core.f =====
rtl/lssc_pkg.sv
rtl/lssc_divider.sv
rtl/local_spline_segment_coefficients_core.sv
tb/local_spline_segment_coefficients_core_test.sv
